@@ rtl/client_session_table_assert.svh @@
// Assertion macros for the client session table.
// Used by the engine; the bodies compile away under SYNTHESIS.
`ifndef CLIENT_SESSION_TABLE_ASSERT_SVH
`define CLIENT_SESSION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CST_ASSERT(label, clk, rst_n, prop, msg)
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/cst_pkg.sv @@
// Shared types, constants and helpers of the client session table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cst_pkg;

  localparam int unsigned TABLE_DEPTH     = 64;
  localparam int unsigned IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W           = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned QP_W            = $clog2(CMD_QUEUE_DEPTH);
  localparam int unsigned QC_W            = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int unsigned APB_ADDR_W      = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [QP_W-1:0]  qptr_t;
  typedef logic [QC_W-1:0]  qcnt_t;

  localparam cnt_t  DEPTH_CNT   = cnt_t'(TABLE_DEPTH);
  localparam qcnt_t QUEUE_FULL  = qcnt_t'(CMD_QUEUE_DEPTH);
  localparam qptr_t QUEUE_LAST  = qptr_t'(CMD_QUEUE_DEPTH - 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd120;
  localparam logic [6:0]  LIMIT_RESET   = 7'd42;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_FANOUT   = 1'b1;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_LIMIT   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_REFRESH = 3'd0,
    ST_REPLACE = 3'd1,
    ST_APPEND  = 3'd2,
    ST_FULL    = 3'd3,
    ST_FANOUT  = 3'd4,
    ST_NONE    = 3'd5
  } status_e;

  typedef enum logic {
    CMD_REGISTER,
    CMD_FANOUT
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DONE
  } eng_state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       dest_ip;
    logic [15:0]       dest_port;
    logic              last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port_no;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [31:0] timeout_seconds;
    logic [6:0]  client_limit;
  } cfg_t;

  // Keep the low bits of a table index for the slot field.
  function automatic logic [SLOT_W-1:0] slot_field(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/cst_front.sv @@
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cst_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output cst_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  cst_pkg::cmd_t  queue_q [cst_pkg::CMD_QUEUE_DEPTH];
  cst_pkg::qptr_t wr_ptr_q, wr_ptr_d;
  cst_pkg::qptr_t rd_ptr_q, rd_ptr_d;
  cst_pkg::qcnt_t fill_q, fill_d;
  cst_pkg::cmd_t  cmd_new;
  logic           push, pop;

  always_comb begin
    cmd_new.kind     = (in_item_i.opcode == cst_pkg::OP_FANOUT) ? cst_pkg::CMD_FANOUT
                                                                 : cst_pkg::CMD_REGISTER;
    cmd_new.ip       = in_item_i.client_ip;
    cmd_new.port     = in_item_i.client_port;
    cmd_new.now_time = in_item_i.now_time;
  end

  assign in_ready_o  = (fill_q != cst_pkg::QUEUE_FULL);
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == cst_pkg::QUEUE_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == cst_pkg::QUEUE_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/cst_engine.sv @@
// Back end: scans memory one slot a cycle unless stalled, making result words.
// Depends on cst_pkg and client_session_table_assert.svh.
`timescale 1ns / 1ps
`include "client_session_table_assert.svh"

module cst_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  cst_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cst_pkg::out_item_t out_item_o
);

  cst_pkg::eng_state_e state_q, state_d;
  cst_pkg::cmd_t       cmd_q, cmd_d;
  cst_pkg::cnt_t       idx_q, idx_d;
  cst_pkg::cnt_t       cnt_q, cnt_d;
  cst_pkg::cnt_t       lim;
  logic                hit_q, hit_d, exp_q, exp_d;
  cst_pkg::idx_t       hit_slot_q, hit_slot_d, exp_slot_q, exp_slot_d;
  logic                held_valid_q, held_valid_d;
  cst_pkg::out_item_t  held_q, held_d;
  logic                out_valid_q, out_valid_d;
  cst_pkg::out_item_t  out_q, out_d;

  cst_pkg::entry_t     mem [cst_pkg::TABLE_DEPTH];
  cst_pkg::entry_t     rdata_q;
  cst_pkg::entry_t     wdata;
  cst_pkg::idx_t       rd_addr, wr_addr;
  logic                mem_we;

  logic                out_can, scan_end, slot_match, slot_expired, fan_emit, lim_capped;
  logic [31:0]         slot_age;
  cst_pkg::out_item_t  slot_item, fin_item, push_item;
  logic                push;

  assign out_can      = !out_valid_q || out_ready_i;
  assign scan_end     = (idx_q == cnt_q);
  assign slot_match   = (rdata_q.addr == cmd_q.ip) && (rdata_q.port_no == cmd_q.port);
  assign slot_age     = cmd_q.now_time - rdata_q.stamp;
  assign slot_expired = slot_age > cfg_i.timeout_seconds;
  assign fan_emit     = !slot_expired && !slot_match;
  assign lim_capped   = 32'(cfg_i.client_limit) > 32'(cst_pkg::TABLE_DEPTH);
  assign lim          = lim_capped ? cst_pkg::DEPTH_CNT : cst_pkg::cnt_t'(cfg_i.client_limit);
  // Read the slot that idx_q will point at, so rdata_q always matches idx_q.
  assign rd_addr      = idx_d[cst_pkg::IDX_W-1:0];

  always_comb begin
    slot_item.status    = cst_pkg::ST_FANOUT;
    slot_item.slot      = cst_pkg::slot_field(idx_q[cst_pkg::IDX_W-1:0]);
    slot_item.dest_ip   = rdata_q.addr;
    slot_item.dest_port = rdata_q.port_no;
    slot_item.last      = 1'b0;
  end

  // Final word of the command and the slot it writes.
  always_comb begin
    fin_item.dest_ip   = cmd_q.ip;
    fin_item.dest_port = cmd_q.port;
    fin_item.last      = 1'b1;
    fin_item.slot      = '0;
    fin_item.status    = cst_pkg::ST_FULL;
    wr_addr            = '0;
    if (cmd_q.kind == cst_pkg::CMD_REGISTER) begin
      if (hit_q) begin
        fin_item.status = cst_pkg::ST_REFRESH;
        wr_addr         = hit_slot_q;
      end else if (exp_q) begin
        fin_item.status = cst_pkg::ST_REPLACE;
        wr_addr         = exp_slot_q;
      end else if (cnt_q < lim) begin
        fin_item.status = cst_pkg::ST_APPEND;
        wr_addr         = cnt_q[cst_pkg::IDX_W-1:0];
      end else begin
        fin_item.dest_ip   = '0;
        fin_item.dest_port = '0;
      end
      if (fin_item.status != cst_pkg::ST_FULL) begin
        fin_item.slot = cst_pkg::slot_field(wr_addr);
      end
    end else if (held_valid_q) begin
      fin_item      = held_q;
      fin_item.last = 1'b1;
    end else begin
      fin_item.status    = cst_pkg::ST_NONE;
      fin_item.dest_ip   = '0;
      fin_item.dest_port = '0;
    end
  end

  assign wdata.addr    = cmd_q.ip;
  assign wdata.port_no = cmd_q.port;
  assign wdata.stamp   = cmd_q.now_time;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cst_pkg::ENG_IDLE: begin
        if (cmd_valid_i) begin
          state_d = cst_pkg::ENG_SCAN;
        end
      end
      cst_pkg::ENG_SCAN: begin
        if (scan_end) begin
          state_d = cst_pkg::ENG_DONE;
        end else if (cmd_q.kind == cst_pkg::CMD_REGISTER && slot_match) begin
          state_d = cst_pkg::ENG_DONE;
        end
      end
      cst_pkg::ENG_DONE: begin
        if (out_can) begin
          state_d = cst_pkg::ENG_IDLE;
        end
      end
      default: state_d = cst_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    exp_d        = exp_q;
    exp_slot_d   = exp_slot_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    cmd_pop_o    = 1'b0;
    push         = 1'b0;
    push_item    = fin_item;
    mem_we       = 1'b0;
    unique case (state_q)
      cst_pkg::ENG_IDLE: begin
        idx_d = '0;
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          hit_d        = 1'b0;
          exp_d        = 1'b0;
          held_valid_d = 1'b0;
        end
      end
      cst_pkg::ENG_SCAN: begin
        if (!scan_end) begin
          if (cmd_q.kind == cst_pkg::CMD_REGISTER) begin
            if (slot_match) begin
              hit_d      = 1'b1;
              hit_slot_d = idx_q[cst_pkg::IDX_W-1:0];
            end else begin
              if (slot_expired && !exp_q) begin
                exp_d      = 1'b1;
                exp_slot_d = idx_q[cst_pkg::IDX_W-1:0];
              end
              idx_d = idx_q + 1'b1;
            end
          end else if (!fan_emit) begin
            idx_d = idx_q + 1'b1;
          end else if (!held_valid_q) begin
            held_valid_d = 1'b1;
            held_d       = slot_item;
            idx_d        = idx_q + 1'b1;
          end else if (out_can) begin
            // Release the held word; a later one exists, so it is not the last.
            push      = 1'b1;
            push_item = held_q;
            held_d    = slot_item;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      cst_pkg::ENG_DONE: begin
        if (out_can) begin
          push         = 1'b1;
          held_valid_d = 1'b0;
          if (cmd_q.kind == cst_pkg::CMD_REGISTER &&
              fin_item.status != cst_pkg::ST_FULL) begin
            mem_we = 1'b1;
          end
          if (cmd_q.kind == cst_pkg::CMD_REGISTER &&
              fin_item.status == cst_pkg::ST_APPEND) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cst_pkg::ENG_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      exp_q        <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      hit_q        <= hit_d;
      exp_q        <= exp_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    hit_slot_q <= hit_slot_d;
    exp_slot_q <= exp_slot_d;
    held_q     <= held_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  `CST_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= cst_pkg::DEPTH_CNT, "entry count above depth")
  `CST_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, cnt_d != cnt_q, (state_q == cst_pkg::ENG_IDLE) && (cnt_q == $past(cnt_q) + 1'b1), "entry count moved other than by one append")
  `CST_ASSERT(a_scan_range, clk_i, rst_ni, (state_q == cst_pkg::ENG_SCAN) |-> (idx_q <= cnt_q), "scan index past entry count")
  `CST_ASSERT(a_held_fanout, clk_i, rst_ni, held_valid_q |-> (cmd_q.kind == cst_pkg::CMD_FANOUT), "held word outside a fanout")

endmodule

@@ rtl/client_session_table.sv @@
// Top level of the client session table: APB registers, front end and engine.
// Depends on cst_pkg, cst_front and cst_engine.
//
//   channel   direction  handshake           payload
//   apb       in/out     psel/penable/pready paddr, pwdata, prdata
//   in        in         in_valid/in_ready   in_item_i  (cst_pkg::in_item_t)
//   out       out        out_valid/out_ready out_item_o (cst_pkg::out_item_t)
//
// An item passes through the engine states idle, scan and done; the scan reads one slot a cycle
// over the single read port of the session memory.
// A fanout stalls its scan only while a word waits in the output register.
// Reset clears the entry count, so the memory needs no clearing pass.
// Two commands queue between front and engine; input stalls when both are taken.
`timescale 1ns / 1ps

module client_session_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cst_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cst_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cst_pkg::out_item_t              out_item_o
);

  cst_pkg::cfg_t     cfg_q, cfg_d;
  cst_pkg::reg_idx_e reg_sel;
  logic              cfg_wr;
  logic              cmd_valid, cmd_pop;
  cst_pkg::cmd_t     cmd;

  assign pready  = 1'b1;
  assign reg_sel = cst_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        cst_pkg::REG_TIMEOUT: cfg_d.timeout_seconds = pwdata;
        cst_pkg::REG_LIMIT:   cfg_d.client_limit    = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cst_pkg::REG_TIMEOUT: prdata = cfg_q.timeout_seconds;
      cst_pkg::REG_LIMIT:   prdata = 32'(cfg_q.client_limit);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_seconds <= cst_pkg::TIMEOUT_RESET;
      cfg_q.client_limit    <= cst_pkg::LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  cst_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
